// ===== src/gdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared widths, mode codes and the scan result type for the DFS unit.
// ----------------------------------------------------------------------------
package gdfs_pkg;

	localparam int NODE_W        = 5;
	localparam int MAX_NODES_DEF = 16;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = 5'd16;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_EDGE   = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// lowest unvisited neighbour above the scan position
	typedef struct packed {
		logic              hit;
		logic [NODE_W-1:0] node;
	} pick_t;

endpackage

// ===== src/gdfs_pick.sv =====
// ----------------------------------------------------------------------------
// gdfs_pick
// Masks an adjacency row and priority-encodes the next neighbour to visit.
// ----------------------------------------------------------------------------
module gdfs_pick #(
	parameter int MAX_NODES = gdfs_pkg::MAX_NODES_DEF
) (
	input  logic [MAX_NODES-1:0]        row,
	input  logic [MAX_NODES-1:0]        visited,
	input  logic [gdfs_pkg::NODE_W-1:0] n_eff,
	input  logic [gdfs_pkg::NODE_W-1:0] scan,
	output gdfs_pkg::pick_t             pick
);

	logic [MAX_NODES-1:0] elig;

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			// node number is i+1
			elig[i] = row[i] && !visited[i] && (int'(n_eff) >= i + 1) && (int'(scan) < i + 1);
		end
	end

	always_comb begin
		pick.hit  = |elig;
		pick.node = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (elig[i]) begin
				pick.node = gdfs_pkg::NODE_W'(i + 1);
			end
		end
	end

endmodule

// ===== src/graph_dfs_adjacency_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_adjacency_matrix_unit
// Clear: done in the idle state; edge add: read row a, write a and read b, write b.
// Search: a push writes the stack and reads the new node's row; a pop reads
// the stack, then the row; a bad start node goes straight to the final result.
// Output stalls hold pushes and the final result. One request at a time.
// Reset: empty graph via per-row valid bits, node_count 16, no clearing pass.
// Adjacency rows and the (node, scan) stack live in synchronous memories.
// ----------------------------------------------------------------------------
module graph_dfs_adjacency_matrix_unit #(
	parameter int MAX_NODES = gdfs_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gdfs_pkg::NODE_W-1:0] cfg_wdata,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  mode,
	input  logic [gdfs_pkg::NODE_W-1:0] node_a,
	input  logic [gdfs_pkg::NODE_W-1:0] node_b,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [gdfs_pkg::NODE_W-1:0] visited_node,
	output logic                        is_last,
	output logic                        error
);

	localparam int NW       = gdfs_pkg::NODE_W;
	localparam int ADDR_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int SP_W     = $clog2(MAX_NODES + 1);
	localparam int NODE_CAP = (MAX_NODES < 31) ? MAX_NODES : 31;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EDGE_A = 6'b000010,
		ST_EDGE_B = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_POP    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t               state_q;
	logic [NW-1:0]        node_count_q;
	logic [NW-1:0]        n_eff;
	logic [MAX_NODES-1:0] row_vld_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [NW-1:0]        edge_a_q, edge_b_q;
	logic [NW-1:0]        top_node_q, top_scan_q;
	logic [SP_W-1:0]      sp_q, sp_m1, sp_m2;
	logic [NW-1:0]        pend_node_q;
	logic                 pend_err_q;
	logic                 res_valid_q, is_last_q, error_q;
	logic [NW-1:0]        visited_node_q;

	// adjacency memory
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic                 adj_rd_en, adj_wr_en;
	logic [ADDR_W-1:0]    adj_rd_addr, adj_wr_addr;
	logic [MAX_NODES-1:0] adj_wr_data;
	logic [MAX_NODES-1:0] row_rd_s1;
	logic                 row_vld_s1;
	logic [MAX_NODES-1:0] row_eff;

	// stack memory: {node, last neighbour tried}
	logic [2*NW-1:0]      stk_mem [MAX_NODES];
	logic                 stk_rd_en, stk_wr_en;
	logic [ADDR_W-1:0]    stk_rd_addr, stk_wr_addr;
	logic [2*NW-1:0]      stk_wr_data;
	logic [2*NW-1:0]      stk_rd_s1;

	gdfs_pkg::pick_t      pick;
	logic                 out_free;
	logic                 emit, emit_last, emit_err;
	logic [NW-1:0]        emit_node;

	function automatic logic [ADDR_W-1:0] node_addr(input logic [NW-1:0] n);
		logic [NW-1:0] m;
		m = n - NW'(1);
		return ADDR_W'(m);
	endfunction

	function automatic logic [MAX_NODES-1:0] node_bit(input logic [NW-1:0] n);
		logic [MAX_NODES-1:0] b;
		b = MAX_NODES'(1) << node_addr(n);
		return b;
	endfunction

	assign n_eff = (node_count_q > NW'(NODE_CAP)) ? NW'(NODE_CAP) : node_count_q;

	function automatic logic in_range(input logic [NW-1:0] n, input logic [NW-1:0] lim);
		return (n != '0) && (n <= lim);
	endfunction

	assign sp_m1    = sp_q - SP_W'(1);
	assign sp_m2    = sp_q - SP_W'(2);
	assign row_eff  = row_vld_s1 ? row_rd_s1 : '0;
	assign out_free = !res_valid_q || res_ready;
	assign req_ready = (state_q == ST_IDLE);

	gdfs_pick #(
		.MAX_NODES(MAX_NODES)
	) u_pick (
		.row    (row_eff),
		.visited(visited_q),
		.n_eff  (n_eff),
		.scan   (top_scan_q),
		.pick   (pick)
	);

	// memory port control
	always_comb begin
		adj_rd_en   = 1'b0;
		adj_rd_addr = '0;
		adj_wr_en   = 1'b0;
		adj_wr_addr = '0;
		adj_wr_data = '0;
		stk_rd_en   = 1'b0;
		stk_rd_addr = sp_m2[ADDR_W-1:0];
		stk_wr_en   = 1'b0;
		stk_wr_addr = sp_m1[ADDR_W-1:0];
		stk_wr_data = {top_node_q, pick.node};
		case (state_q)
			ST_IDLE: begin
				adj_rd_addr = node_addr(node_a);
				if (req_valid) begin
					if (mode == gdfs_pkg::MODE_EDGE && in_range(node_a, n_eff) &&
					    in_range(node_b, n_eff)) begin
						adj_rd_en = 1'b1;
					end else if (mode == gdfs_pkg::MODE_SEARCH && in_range(node_a, n_eff)) begin
						adj_rd_en = 1'b1;
					end
				end
			end
			ST_EDGE_A: begin
				// read of row b here sees the old row if b equals a
				adj_wr_en   = 1'b1;
				adj_wr_addr = node_addr(edge_a_q);
				adj_wr_data = row_eff | node_bit(edge_b_q);
				adj_rd_en   = 1'b1;
				adj_rd_addr = node_addr(edge_b_q);
			end
			ST_EDGE_B: begin
				adj_wr_en   = 1'b1;
				adj_wr_addr = node_addr(edge_b_q);
				adj_wr_data = row_eff | node_bit(edge_a_q);
			end
			ST_SCAN: begin
				if (pick.hit) begin
					if (out_free) begin
						adj_rd_en   = 1'b1;
						adj_rd_addr = node_addr(pick.node);
						stk_wr_en   = 1'b1;
					end
				end else if (sp_q != SP_W'(1)) begin
					stk_rd_en = 1'b1;
				end
			end
			ST_POP: begin
				adj_rd_en   = 1'b1;
				adj_rd_addr = node_addr(stk_rd_s1[2*NW-1:NW]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_wr_en) begin
			adj_mem[adj_wr_addr] <= adj_wr_data;
		end
		if (adj_rd_en) begin
			row_rd_s1 <= adj_mem[adj_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_wr_en) begin
			stk_mem[stk_wr_addr] <= stk_wr_data;
		end
		if (stk_rd_en) begin
			stk_rd_s1 <= stk_mem[stk_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_s1 <= 1'b0;
		end else if (adj_rd_en) begin
			row_vld_s1 <= row_vld_q[adj_rd_addr];
		end
	end

	// result selection
	always_comb begin
		emit      = 1'b0;
		emit_node = pend_node_q;
		emit_last = 1'b0;
		emit_err  = 1'b0;
		if (state_q == ST_SCAN && pick.hit && out_free) begin
			emit = 1'b1;
		end else if (state_q == ST_FINISH && out_free) begin
			emit      = 1'b1;
			emit_last = 1'b1;
			emit_err  = pend_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q    <= 1'b0;
			visited_node_q <= '0;
			is_last_q      <= 1'b0;
			error_q        <= 1'b0;
		end else if (emit) begin
			res_valid_q    <= 1'b1;
			visited_node_q <= emit_node;
			is_last_q      <= emit_last;
			error_q        <= emit_err;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid    = res_valid_q;
	assign visited_node = visited_node_q;
	assign is_last      = is_last_q;
	assign error        = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= gdfs_pkg::NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_vld_q   <= '0;
			visited_q   <= '0;
			edge_a_q    <= '0;
			edge_b_q    <= '0;
			top_node_q  <= '0;
			top_scan_q  <= '0;
			sp_q        <= '0;
			pend_node_q <= '0;
			pend_err_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (mode)
							gdfs_pkg::MODE_CLEAR: begin
								row_vld_q <= '0;
							end
							gdfs_pkg::MODE_EDGE: begin
								if (in_range(node_a, n_eff) && in_range(node_b, n_eff)) begin
									edge_a_q <= node_a;
									edge_b_q <= node_b;
									state_q  <= ST_EDGE_A;
								end
							end
							gdfs_pkg::MODE_SEARCH: begin
								if (in_range(node_a, n_eff)) begin
									visited_q   <= node_bit(node_a);
									top_node_q  <= node_a;
									top_scan_q  <= '0;
									sp_q        <= SP_W'(1);
									pend_node_q <= node_a;
									pend_err_q  <= 1'b0;
									state_q     <= ST_SCAN;
								end else begin
									pend_node_q <= '0;
									pend_err_q  <= 1'b1;
									state_q     <= ST_FINISH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_EDGE_A: begin
					row_vld_q[node_addr(edge_a_q)] <= 1'b1;
					state_q <= ST_EDGE_B;
				end
				ST_EDGE_B: begin
					row_vld_q[node_addr(edge_b_q)] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (pick.hit) begin
						// push: parent keeps found node as its scan position
						if (out_free) begin
							visited_q   <= visited_q | node_bit(pick.node);
							pend_node_q <= pick.node;
							top_node_q  <= pick.node;
							top_scan_q  <= '0;
							sp_q        <= sp_q + SP_W'(1);
						end
					end else if (sp_q == SP_W'(1)) begin
						sp_q    <= '0;
						state_q <= ST_FINISH;
					end else begin
						sp_q    <= sp_m1;
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					top_node_q <= stk_rd_s1[2*NW-1:NW];
					top_scan_q <= stk_rd_s1[NW-1:0];
					state_q    <= ST_SCAN;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(MAX_NODES))
		else $error("stack pointer beyond depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (sp_q == '0))
		else $error("stack not empty while taking a request");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (sp_q != '0))
		else $error("scan with empty stack");

	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> visited_q[node_addr(top_node_q)])
		else $error("top of stack not marked visited");
`endif

endmodule
